// File: rtl/core/ilpd_pkg.sv
package ilpd_pkg;

    // kind codes carried on the result tuser
    typedef enum logic [1:0] {
        KIND_ELEM  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    // header byte fields and datapath widths
    localparam int          BYTE_BITS  = 8;
    localparam int          LEN_BITS   = 7;
    localparam logic [6:0]  LEN_MASK   = 7'h7F;
    localparam int          COUNT_BITS = 31;
    localparam int          OUT_BITS   = 32;

endpackage

// File: rtl/core/int_list_length_prefixed_decoder_top.sv
// Length-prefixed integer list decoder.
// The slave stream carries one encoded byte per word in s_axis_tdata, with
// s_axis_tlast marking the last byte of a buffer. Each list is a count
// integer followed by that many element integers; an integer is a header
// byte (bit 7 sign, bits 6..0 byte count) and its magnitude bytes, most
// significant first.
// The master stream returns one word per decoded element (tuser kind
// element, tlast on the last element of its list), one empty-list word
// for a zero or negative count, and one error word when a buffer ends
// inside a list, after which the decoder is back in its reset state.
// Throughput is one byte per cycle: every byte updates the decode state and
// its result, if any, is written into the output register at the edge that
// takes the byte and is offered from the next cycle on.
// The output register is a single stage, so a new byte is taken whenever
// that register is empty or being read in the same cycle; while the
// receiver stalls with a word pending, s_axis_tready drops and the decoder
// holds its state.
// Synchronous active-low reset returns the decoder to expect a count header
// and empties the output register.
module int_list_length_prefixed_decoder_top #(
    parameter int VALUE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ilpd_pkg::BYTE_BITS-1:0]    s_axis_tdata,   // [7:0] data_byte
    input  logic                              s_axis_tlast,   // buffer_end
    // master stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ilpd_pkg::OUT_BITS-1:0]     m_axis_tdata,   // [31:0] value
    output logic [1:0]                        m_axis_tuser,   // [1:0] kind
    output logic                              m_axis_tlast    // list_last
);
    import ilpd_pkg::*;

    localparam int EXT_W = (VALUE_BITS > OUT_BITS) ? VALUE_BITS : OUT_BITS;

    typedef enum logic [1:0] {
        PH_COUNT_HDR = 2'd0,
        PH_COUNT_MAG = 2'd1,
        PH_ELEM_HDR  = 2'd2,
        PH_ELEM_MAG  = 2'd3
    } t_phase;

    t_phase                  r_phase,  n_phase;
    logic [LEN_BITS-1:0]     r_bytes,  n_bytes;
    logic                    r_sign,   n_sign;
    logic [VALUE_BITS-1:0]   r_acc,    n_acc;
    logic [COUNT_BITS-1:0]   r_elems,  n_elems;

    logic                    r_out_valid;
    logic [OUT_BITS-1:0]     r_value,  n_value;
    t_kind                   r_kind,   n_kind;
    logic                    r_last,   n_last;

    logic                    accept;
    logic                    done;
    logic                    have;
    logic                    is_hdr;
    logic                    cur_sign;
    logic [VALUE_BITS-1:0]   cur_acc;
    logic [VALUE_BITS-1:0]   fin;
    logic                    fin_neg;
    logic signed [EXT_W-1:0] fin_ext;
    logic [LEN_BITS-1:0]     bytes_dec;
    logic [COUNT_BITS-1:0]   elems_dec;
    logic [VALUE_BITS+BYTE_BITS-1:0] acc_shift;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_value;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;

    // shared arithmetic for the byte step and the finished integer
    assign acc_shift = {r_acc, s_axis_tdata};
    assign bytes_dec = r_bytes - LEN_BITS'(1);
    assign is_hdr    = (r_phase == PH_COUNT_HDR) || (r_phase == PH_ELEM_HDR);
    assign cur_sign  = is_hdr ? s_axis_tdata[BYTE_BITS-1] : r_sign;
    assign cur_acc   = is_hdr ? '0 : acc_shift[VALUE_BITS-1:0];
    assign fin       = cur_sign ? (VALUE_BITS'(0) - cur_acc) : cur_acc;
    assign fin_neg   = fin[VALUE_BITS-1];
    assign fin_ext   = EXT_W'(signed'(fin));
    assign elems_dec = r_elems - COUNT_BITS'(1);

    // decode one byte
    always_comb begin
        n_phase = r_phase;
        n_bytes = r_bytes;
        n_sign  = r_sign;
        n_acc   = r_acc;
        n_elems = r_elems;
        n_value = '0;
        n_kind  = KIND_ELEM;
        n_last  = 1'b0;
        have    = 1'b0;
        done    = 1'b0;

        // header or magnitude byte
        case (r_phase)
            PH_COUNT_HDR, PH_ELEM_HDR: begin
                n_sign  = s_axis_tdata[BYTE_BITS-1];
                n_bytes = s_axis_tdata[LEN_BITS-1:0] & LEN_MASK;
                n_acc   = '0;
                if (n_bytes == '0) begin
                    done = 1'b1;
                end else begin
                    n_phase = (r_phase == PH_COUNT_HDR) ? PH_COUNT_MAG : PH_ELEM_MAG;
                end
            end
            default: begin
                n_acc   = acc_shift[VALUE_BITS-1:0];
                n_bytes = bytes_dec;
                done    = (bytes_dec == '0);
            end
        endcase

        // integer complete
        if (done) begin
            n_sign = 1'b0;
            n_acc  = '0;
            if (r_phase == PH_COUNT_HDR || r_phase == PH_COUNT_MAG) begin
                if (fin == '0 || fin_neg) begin
                    have    = 1'b1;
                    n_kind  = KIND_EMPTY;
                    n_last  = 1'b1;
                    n_phase = PH_COUNT_HDR;
                end else begin
                    // counts above the element counter range saturate
                    n_elems = (|(fin >> COUNT_BITS)) ? '1 : COUNT_BITS'(fin);
                    n_phase = PH_ELEM_HDR;
                end
            end else begin
                have    = 1'b1;
                n_value = fin_ext[OUT_BITS-1:0];
                n_kind  = KIND_ELEM;
                n_elems = elems_dec;
                if (elems_dec == '0) begin
                    n_last  = 1'b1;
                    n_phase = PH_COUNT_HDR;
                end else begin
                    n_phase = PH_ELEM_HDR;
                end
            end
        end

        // buffer ends inside a list
        if (s_axis_tlast && n_phase != PH_COUNT_HDR) begin
            n_phase = PH_COUNT_HDR;
            n_bytes = '0;
            n_sign  = 1'b0;
            n_acc   = '0;
            n_elems = '0;
            have    = 1'b1;
            n_value = '0;
            n_kind  = KIND_ERROR;
            n_last  = 1'b1;
        end
    end

    // decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COUNT_HDR;
            r_bytes <= '0;
            r_sign  <= 1'b0;
            r_acc   <= '0;
            r_elems <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_bytes <= n_bytes;
            r_sign  <= n_sign;
            r_acc   <= n_acc;
            r_elems <= n_elems;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= have;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (accept && have) begin
            r_value <= n_value;
            r_kind  <= n_kind;
            r_last  <= n_last;
        end
    end

endmodule
